/* design/mjw_pkg.sv */
package mjw_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int DIST_W  = 8;
    localparam int ANG_W   = 9;
    localparam int DUTY_W  = 10;
    localparam int STEP_W  = 4;
    localparam int MAG_W   = 6;    // |g| <= 45
    localparam int DM_W    = 14;   // distance * |g| <= 11475
    localparam int P_W     = 23;   // max_pwm * (distance * |g|) when below 4500
    localparam int PROD_W  = 46;   // P_W + reciprocal width
    localparam int SUM_W   = 10;   // reduced angle plus offset, below 630
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Wave geometry in degrees
    localparam logic [ANG_W-1:0] FULL_TURN = 9'd360;
    localparam logic [SUM_W-1:0] DEG_0     = 10'd0;
    localparam logic [SUM_W-1:0] DEG_90    = 10'd90;
    localparam logic [SUM_W-1:0] DEG_135   = 10'd135;
    localparam logic [SUM_W-1:0] DEG_180   = 10'd180;
    localparam logic [SUM_W-1:0] DEG_270   = 10'd270;
    localparam logic [SUM_W-1:0] DEG_315   = 10'd315;
    localparam logic [SUM_W-1:0] DEG_360   = 10'd360;
    localparam logic [MAG_W-1:0] WAVE_FULL = 6'd45;

    // Scale by 1/4500: floor(p * RECIP >> DIV_SHIFT) is exact for p < 2^23
    localparam logic [DM_W-1:0]  SAT_LIMIT = 14'd4500;
    localparam logic [P_W-1:0]   RECIP     = 23'd7635498;
    localparam int               DIV_SHIFT = 35;

    // Register reset values
    localparam logic [STEP_W-1:0] DECAY_STEP_RST = 4'd1;
    localparam logic [DUTY_W-1:0] MAX_PWM_RST    = 10'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_MOVE    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY_STEP = 1'd0,
        REG_MAX_PWM    = 1'd1
    } t_reg_idx;

    // Controller to datapath
    typedef struct packed {
        logic cap_move;     // store new distance/angle/stick
        logic cap_tick;     // decay held distance, force left mode
        logic set_release;  // arm decay
        logic load_out;     // latch finished result into output register
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic released;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_wheel0;
        logic [DUTY_W-1:0] duty_wheel1;
        logic [DUTY_W-1:0] duty_wheel2;
        logic [DUTY_W-1:0] duty_wheel3;
        logic              dir_wheel0;
        logic              dir_wheel1;
        logic              dir_wheel2;
        logic              dir_wheel3;
    } t_res;

endpackage

/* design/mjw_cmd_if.sv */
interface mjw_cmd_if
    import mjw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic              stick_right;
    logic [DIST_W-1:0] distance;
    logic [ANG_W-1:0]  angle;

    modport source (output valid, command, stick_right, distance, angle, input ready);
    modport sink   (input valid, command, stick_right, distance, angle, output ready);
endinterface

/* design/mjw_res_if.sv */
interface mjw_res_if
    import mjw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_wheel0;
    logic [DUTY_W-1:0] duty_wheel1;
    logic [DUTY_W-1:0] duty_wheel2;
    logic [DUTY_W-1:0] duty_wheel3;
    logic              dir_wheel0;
    logic              dir_wheel1;
    logic              dir_wheel2;
    logic              dir_wheel3;

    modport source (output valid, duty_wheel0, duty_wheel1, duty_wheel2, duty_wheel3,
                    dir_wheel0, dir_wheel1, dir_wheel2, dir_wheel3, input ready);
    modport sink   (input valid, duty_wheel0, duty_wheel1, duty_wheel2, duty_wheel3,
                    dir_wheel0, dir_wheel1, dir_wheel2, dir_wheel3, output ready);
endinterface

/* design/mjw_ctrl.sv */
module mjw_ctrl
    import mjw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_command,
    output logic             o_ready,
    input  t_stat            i_stat,
    output t_ctrl            o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAVE,
        S_SCALE,
        S_DIV
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    logic   accept;

    assign accept  = i_valid && r_ready;
    assign o_ready = r_ready;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_MOVE: begin
                            o_ctrl.cap_move = 1'b1;
                            n_state = S_WAVE;
                        end
                        CMD_RELEASE: begin
                            o_ctrl.set_release = 1'b1;
                        end
                        CMD_TICK: begin
                            if (i_stat.released) begin
                                o_ctrl.cap_tick = 1'b1;
                                n_state = S_WAVE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WAVE:  n_state = S_SCALE;
            S_SCALE: n_state = S_DIV;
            S_DIV: begin
                // wait here until the output register can take the result
                if (i_stat.out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

endmodule

/* design/mjw_dp.sv */
module mjw_dp
    import mjw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_stick_right,
    input  logic [DIST_W-1:0]     i_distance,
    input  logic [ANG_W-1:0]      i_angle,
    input  t_ctrl                 i_ctrl,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_res                  o_res
);

    // Trapezoid sample: {negative, |g|} for d in 0..359
    function automatic logic [MAG_W:0] wave(input logic [SUM_W-1:0] d);
        logic [SUM_W-1:0] m;
        logic             neg;
        m   = {4'd0, WAVE_FULL};
        neg = 1'b0;
        if (d < DEG_90) begin
            neg = 1'b0;
        end else if (d < DEG_180) begin
            neg = (d > DEG_135);
            m   = neg ? d - DEG_135 : DEG_135 - d;
        end else if (d < DEG_270) begin
            neg = 1'b1;
        end else begin
            neg = (d < DEG_315);
            m   = neg ? DEG_315 - d : d - DEG_315;
        end
        return {neg, m[MAG_W-1:0]};
    endfunction

    logic [STEP_W-1:0] r_decay_step;
    logic [DUTY_W-1:0] r_max_pwm;
    logic [DIST_W-1:0] r_held_dist;
    logic [ANG_W-1:0]  r_held_ang;
    logic              r_right;
    logic              r_released;

    logic [DM_W-1:0]   r_dm   [2];
    logic              r_neg1 [2];
    logic [P_W-1:0]    r_p    [2];
    logic              r_sat  [2];
    logic              r_neg2 [2];

    logic              r_out_valid;
    t_res              r_res;

    logic [ANG_W-1:0]  ang_red;
    logic [SUM_W-1:0]  offs   [2];
    logic [SUM_W-1:0]  sum    [2];
    logic [SUM_W-1:0]  deg    [2];
    logic [MAG_W:0]    wv     [2];
    logic [DM_W-1:0]   n_dm   [2];
    logic              n_neg1 [2];
    logic [PROD_W-1:0] prod   [2];
    logic [DUTY_W-1:0] duty   [2];
    logic [DIST_W-1:0] decayed;
    t_res              n_res;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_step <= DECAY_STEP_RST;
            r_max_pwm    <= MAX_PWM_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DECAY_STEP: r_decay_step <= i_cfg_data[STEP_W-1:0];
                REG_MAX_PWM:    r_max_pwm    <= i_cfg_data[DUTY_W-1:0];
                default:        r_max_pwm    <= r_max_pwm;
            endcase
        end
    end

    // Held joystick state; decay floors at zero
    assign decayed = (r_held_dist > DIST_W'(r_decay_step))
                   ? r_held_dist - DIST_W'(r_decay_step) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_dist <= '0;
            r_held_ang  <= '0;
            r_right     <= 1'b0;
            r_released  <= 1'b0;
        end else if (i_ctrl.cap_move) begin
            r_held_dist <= i_distance;
            r_held_ang  <= i_angle;
            r_right     <= i_stick_right;
            r_released  <= 1'b0;
        end else if (i_ctrl.cap_tick) begin
            r_held_dist <= decayed;
            r_right     <= 1'b0;
        end else if (i_ctrl.set_release) begin
            r_released  <= 1'b1;
        end
    end

    // Stage 1: angle reduction, wave sample, distance * |g|
    always_comb begin
        ang_red = (r_held_ang >= FULL_TURN) ? r_held_ang - FULL_TURN : r_held_ang;
        offs[0] = r_right ? DEG_180 : DEG_0;
        offs[1] = r_right ? DEG_90  : DEG_270;
        for (int l = 0; l < 2; l++) begin
            sum[l]    = SUM_W'(ang_red) + offs[l];
            deg[l]    = (sum[l] >= DEG_360) ? sum[l] - DEG_360 : sum[l];
            wv[l]     = wave(deg[l]);
            n_dm[l]   = DM_W'(r_held_dist) * DM_W'(wv[l][MAG_W-1:0]);
            n_neg1[l] = (r_held_dist != '0) && wv[l][MAG_W];
        end
    end

    // Stages 2 and 3 registers: scale by max_pwm, then divide by 4500
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_dm[l]   <= n_dm[l];
            r_neg1[l] <= n_neg1[l];
            r_sat[l]  <= (r_dm[l] >= SAT_LIMIT);
            r_p[l]    <= P_W'(r_max_pwm) * P_W'(r_dm[l][DM_W-2:0]);
            r_neg2[l] <= r_neg1[l];
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            prod[l] = PROD_W'(r_p[l]) * PROD_W'(RECIP);
            duty[l] = r_sat[l] ? r_max_pwm : prod[l][DIV_SHIFT +: DUTY_W];
        end
    end

    // Wheel mapping: lane 0 is A or C, lane 1 is B or D
    always_comb begin
        if (!r_right) begin
            n_res.duty_wheel0 = duty[0];
            n_res.duty_wheel1 = duty[1];
            n_res.duty_wheel2 = duty[1];
            n_res.duty_wheel3 = duty[0];
            n_res.dir_wheel0  = r_neg2[0];
            n_res.dir_wheel1  = !r_neg2[1];
            n_res.dir_wheel2  = r_neg2[1];
            n_res.dir_wheel3  = !r_neg2[0];
        end else begin
            n_res.duty_wheel0 = duty[0];
            n_res.duty_wheel1 = duty[1];
            n_res.duty_wheel2 = duty[0];
            n_res.duty_wheel3 = duty[1];
            n_res.dir_wheel0  = !r_neg2[0];
            n_res.dir_wheel1  = r_neg2[1];
            n_res.dir_wheel2  = !r_neg2[0];
            n_res.dir_wheel3  = r_neg2[1];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_res           = r_res;
    assign o_stat.released = r_released;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

/* design/mecanum_joystick_wheel_mixer_core.sv */
// Mecanum wheel mixer: joystick request in, four duties and directions out.
// A request is captured into the held registers on accept, then walks the wave, scale and divide
// stages into the output reg; the divide stage waits until the output register is free. No new
// request is accepted while one walks through the three-stage wave/scale/divide datapath.
// Release and ignored requests produce no result.
// Reset (synchronous, active low) restores decay_step=1, max_pwm=255 and clears held state.
module mecanum_joystick_wheel_mixer_core
    import mjw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mjw_cmd_if.sink               i_cmd,
    mjw_res_if.source             o_res
);

    t_ctrl ctrl;
    t_stat stat;
    t_res  res;
    logic  out_valid;

    mjw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .i_command (i_cmd.command),
        .o_ready   (i_cmd.ready),
        .i_stat    (stat),
        .o_ctrl    (ctrl)
    );

    mjw_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_stick_right (i_cmd.stick_right),
        .i_distance    (i_cmd.distance),
        .i_angle       (i_cmd.angle),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (out_valid),
        .o_res         (res)
    );

    assign o_res.valid       = out_valid;
    assign o_res.duty_wheel0 = res.duty_wheel0;
    assign o_res.duty_wheel1 = res.duty_wheel1;
    assign o_res.duty_wheel2 = res.duty_wheel2;
    assign o_res.duty_wheel3 = res.duty_wheel3;
    assign o_res.dir_wheel0  = res.dir_wheel0;
    assign o_res.dir_wheel1  = res.dir_wheel1;
    assign o_res.dir_wheel2  = res.dir_wheel2;
    assign o_res.dir_wheel3  = res.dir_wheel3;

    // Result only lands in the output register when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.load_out |-> stat.out_free)
        else $error("result loaded over an untaken result");

    // A release request arms the decay
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.set_release |=> stat.released)
        else $error("release did not arm decay");

    // A move request disarms the decay
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.cap_move |=> !stat.released)
        else $error("move left decay armed");

    // No new request is taken while a request is in the datapath
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.cap_move || ctrl.cap_tick) |=> !i_cmd.ready)
        else $error("request taken while busy");

endmodule
